// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- sv/mwas_pkg.sv -----
// ----------------------------------------------------------------------------
// mwas_pkg
// Types and constants shared by the assignment solver modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mwas_pkg;

    localparam int DEF_MAX_SIZE = 16;
    localparam int WEIGHT_W     = 16;
    localparam int PORT_IDX_W   = 6;
    localparam int TOTAL_W      = 22;
    localparam int SIZE_W       = 7;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int LBL_W        = 32;

    localparam logic [SIZE_W-1:0] DEF_ACTIVE_SIZE = 7'd16;

    // Slack of a column not yet reached; stays positive under any relabel sequence.
    localparam logic signed [LBL_W-1:0] SLACK_INF = 32'sh4000_0000;

    typedef enum logic [13:0] {
        S_CLEAR      = 14'b00000000000001,
        S_IDLE       = 14'b00000000000010,
        S_INIT_RD    = 14'b00000000000100,
        S_INIT_ACC   = 14'b00000000001000,
        S_PHASE_CHK  = 14'b00000000010000,
        S_PHASE_INIT = 14'b00000000100000,
        S_POP        = 14'b00000001000000,
        S_SCAN_RD    = 14'b00000010000000,
        S_SCAN_EV    = 14'b00000100000000,
        S_TAO        = 14'b00001000000000,
        S_APPLY      = 14'b00010000000000,
        S_FLIP       = 14'b00100000000000,
        S_SUM        = 14'b01000000000000,
        S_EMIT       = 14'b10000000000000
    } state_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WRITE,
        OP_LOAD,
        OP_CLEAR,
        OP_INIT_RD,
        OP_INIT_ACC,
        OP_PHASE_CHK,
        OP_PHASE_INIT,
        OP_POP,
        OP_SCAN_RD,
        OP_SCAN_EV,
        OP_TAO,
        OP_APPLY,
        OP_FLIP,
        OP_SUM,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic init_last;
        logic unmatched_zero;
        logic any_pending;
        logic scan_skip;
        logic scan_last;
        logic aug;
        logic tao_inf;
        logic freec_found;
        logic flip_done;
        logic sweep_last;
    } dp_status_t;

endpackage

// ----- sv/mwas_ctrl.sv -----
// ----------------------------------------------------------------------------
// mwas_ctrl
// Sequencer of the solver: walks the solve phases and commands the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwas_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 kind,
    input  mwas_pkg::dp_status_t status,
    output mwas_pkg::dp_cmd_t    cmd,
    output logic                 busy
);

    mwas_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = mwas_pkg::OP_NOP;
        case (state_reg)
            mwas_pkg::S_CLEAR:
            begin
                cmd.op = mwas_pkg::OP_CLEAR;
                if (status.clear_done)
                    state_next = mwas_pkg::S_IDLE;
            end
            mwas_pkg::S_IDLE:
            begin
                if (start && kind)
                begin
                    cmd.op     = mwas_pkg::OP_LOAD;
                    state_next = mwas_pkg::S_INIT_RD;
                end
                else if (start)
                    cmd.op = mwas_pkg::OP_WRITE;
            end
            mwas_pkg::S_INIT_RD:
            begin
                cmd.op     = mwas_pkg::OP_INIT_RD;
                state_next = mwas_pkg::S_INIT_ACC;
            end
            mwas_pkg::S_INIT_ACC:
            begin
                cmd.op     = mwas_pkg::OP_INIT_ACC;
                state_next = status.init_last ? mwas_pkg::S_PHASE_CHK : mwas_pkg::S_INIT_RD;
            end
            mwas_pkg::S_PHASE_CHK:
            begin
                cmd.op     = mwas_pkg::OP_PHASE_CHK;
                state_next = status.unmatched_zero ? mwas_pkg::S_SUM : mwas_pkg::S_PHASE_INIT;
            end
            mwas_pkg::S_PHASE_INIT:
            begin
                cmd.op     = mwas_pkg::OP_PHASE_INIT;
                state_next = mwas_pkg::S_POP;
            end
            mwas_pkg::S_POP:
            begin
                cmd.op     = mwas_pkg::OP_POP;
                state_next = status.any_pending ? mwas_pkg::S_SCAN_RD : mwas_pkg::S_TAO;
            end
            mwas_pkg::S_SCAN_RD:
            begin
                cmd.op = mwas_pkg::OP_SCAN_RD;
                if (!status.scan_skip)
                    state_next = mwas_pkg::S_SCAN_EV;
                else if (status.scan_last)
                    state_next = mwas_pkg::S_POP;
            end
            mwas_pkg::S_SCAN_EV:
            begin
                cmd.op = mwas_pkg::OP_SCAN_EV;
                if (status.aug)
                    state_next = mwas_pkg::S_FLIP;
                else if (status.scan_last)
                    state_next = mwas_pkg::S_POP;
                else
                    state_next = mwas_pkg::S_SCAN_RD;
            end
            mwas_pkg::S_TAO:
            begin
                cmd.op = mwas_pkg::OP_TAO;
                if (status.sweep_last)
                    state_next = status.tao_inf ? mwas_pkg::S_SUM : mwas_pkg::S_APPLY;
            end
            mwas_pkg::S_APPLY:
            begin
                cmd.op = mwas_pkg::OP_APPLY;
                if (status.sweep_last)
                    state_next = status.freec_found ? mwas_pkg::S_FLIP : mwas_pkg::S_POP;
            end
            mwas_pkg::S_FLIP:
            begin
                cmd.op = mwas_pkg::OP_FLIP;
                if (status.flip_done)
                    state_next = mwas_pkg::S_PHASE_CHK;
            end
            mwas_pkg::S_SUM:
            begin
                cmd.op = mwas_pkg::OP_SUM;
                if (status.sweep_last)
                    state_next = mwas_pkg::S_EMIT;
            end
            mwas_pkg::S_EMIT:
            begin
                cmd.op = mwas_pkg::OP_EMIT;
                if (status.sweep_last)
                    state_next = mwas_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mwas_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mwas_pkg::S_CLEAR;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != mwas_pkg::S_IDLE);

endmodule

// ----- sv/mwas_datapath.sv -----
// ----------------------------------------------------------------------------
// mwas_datapath
// Weight memory, labels, slacks, matching and tree state with their update
// logic; one command from the sequencer is carried out per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwas_datapath #(
    parameter int MAX_SIZE = mwas_pkg::DEF_MAX_SIZE
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mwas_pkg::dp_cmd_t                   cmd,
    input  logic [mwas_pkg::SIZE_W-1:0]         active_size,
    input  logic [mwas_pkg::PORT_IDX_W-1:0]     row,
    input  logic [mwas_pkg::PORT_IDX_W-1:0]     col,
    input  logic [mwas_pkg::WEIGHT_W-1:0]       weight,
    output mwas_pkg::dp_status_t                status,
    output logic                                result_valid,
    output logic [mwas_pkg::PORT_IDX_W-1:0]     out_row,
    output logic [mwas_pkg::PORT_IDX_W-1:0]     out_col,
    output logic [mwas_pkg::TOTAL_W-1:0]        total,
    output logic                                last
);

    localparam int IDX_W   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int CNT_W   = $clog2(MAX_SIZE + 1);
    localparam int GUARD_W = CNT_W + 1;
    localparam int DEPTH   = MAX_SIZE * MAX_SIZE;
    localparam int AW      = $clog2(DEPTH);
    localparam int LW      = mwas_pkg::LBL_W;
    localparam int WW      = mwas_pkg::WEIGHT_W;
    localparam int PW      = mwas_pkg::PORT_IDX_W;

    localparam logic [AW-1:0]    MAX_A    = AW'(MAX_SIZE);
    localparam logic [AW-1:0]    CLR_LAST = AW'(DEPTH - 1);
    localparam logic [CNT_W-1:0] MAX_N    = CNT_W'(MAX_SIZE);

    // Weight memory and its registered read port.
    logic [WW-1:0] mem [DEPTH];
    logic [WW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic [WW-1:0] wr_data;

    logic [AW-1:0]    clr_reg, clr_next;
    logic [CNT_W-1:0] n_reg, n_next, unm_reg, unm_next;
    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IDX_W-1:0] r_reg, r_next, c_reg, c_next, freec_reg, freec_next;
    logic             freec_v_reg, freec_v_next;
    logic [GUARD_W-1:0] guard_reg, guard_next;
    logic [WW-1:0]    mx_reg, mx_next;
    logic signed [LW-1:0] tao_reg, tao_next, total_reg, total_next;

    logic signed [LW-1:0] rl_reg [MAX_SIZE];
    logic signed [LW-1:0] rl_next [MAX_SIZE];
    logic signed [LW-1:0] cl_reg [MAX_SIZE];
    logic signed [LW-1:0] cl_next [MAX_SIZE];
    logic signed [LW-1:0] slack_reg [MAX_SIZE];
    logic signed [LW-1:0] slack_next [MAX_SIZE];
    logic [IDX_W-1:0] parent_reg [MAX_SIZE];
    logic [IDX_W-1:0] parent_next [MAX_SIZE];
    logic [IDX_W-1:0] rmate_reg [MAX_SIZE];
    logic [IDX_W-1:0] rmate_next [MAX_SIZE];
    logic [IDX_W-1:0] cmate_reg [MAX_SIZE];
    logic [IDX_W-1:0] cmate_next [MAX_SIZE];
    logic [MAX_SIZE-1:0] row_m_reg, row_m_next, col_m_reg, col_m_next;
    logic [MAX_SIZE-1:0] tree_reg, tree_next, pend_reg, pend_next;

    logic          res_v_reg, res_v_next, last_reg, last_next;
    logic [PW-1:0] orow_reg, orow_next, ocol_reg, ocol_next;

    logic [IDX_W-1:0] i_idx, j_idx, k_idx, pop_idx, flip_row, flip_nxt;
    logic [CNT_W-1:0] n_last, size_n;
    logic             pend_any, flip_nxt_v, scan_skip, scan_last, sweep_last;
    logic             s_better, apply_free;
    logic signed [LW-1:0] w_ext, s_val, sl_sub, tao_cand;
    logic [WW-1:0]    mx_cur;

    function automatic logic [AW-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
        cell_addr = AW'(r) * MAX_A + AW'(c);
    endfunction

    assign i_idx  = i_reg[IDX_W-1:0];
    assign j_idx  = j_reg[IDX_W-1:0];
    assign k_idx  = k_reg[IDX_W-1:0];
    assign n_last = n_reg - CNT_W'(1);

    assign size_n = (active_size == '0) ? CNT_W'(1) :
                    (active_size > mwas_pkg::SIZE_W'(MAX_SIZE)) ? MAX_N :
                    CNT_W'(active_size);

    assign w_ext      = $signed({{(LW-WW){1'b0}}, rd_data_reg});
    assign s_val      = rl_reg[r_reg] + cl_reg[j_idx] - w_ext;
    assign s_better   = (s_val < slack_reg[j_idx]);
    assign scan_skip  = row_m_reg[r_reg] && (rmate_reg[r_reg] == j_idx);
    assign scan_last  = (j_reg == n_last);
    assign sweep_last = (k_reg == n_last);
    assign mx_cur     = (rd_data_reg > mx_reg) ? rd_data_reg : mx_reg;

    assign sl_sub     = slack_reg[k_idx] - tao_reg;
    assign apply_free = (slack_reg[k_idx] != '0) && (sl_sub == '0) && !col_m_reg[k_idx];
    assign tao_cand   = ((slack_reg[k_idx] > 0) && (slack_reg[k_idx] < tao_reg)) ?
                        slack_reg[k_idx] : tao_reg;

    assign flip_row   = parent_reg[c_reg];
    assign flip_nxt   = rmate_reg[flip_row];
    assign flip_nxt_v = row_m_reg[flip_row];

    // Lowest pending row.
    always_comb
    begin
        pop_idx = '0;
        for (int q = MAX_SIZE - 1; q >= 0; q--)
        begin
            if (pend_reg[q])
                pop_idx = IDX_W'(q);
        end
    end
    assign pend_any = |pend_reg;

    always_comb
    begin
        status.clear_done     = (clr_reg == CLR_LAST);
        status.init_last      = (i_reg == n_last) && (j_reg == n_last);
        status.unmatched_zero = (unm_reg == '0);
        status.any_pending    = pend_any;
        status.scan_skip      = scan_skip;
        status.scan_last      = scan_last;
        status.aug            = s_better && (s_val == '0) && !col_m_reg[j_idx];
        status.tao_inf        = (tao_cand == mwas_pkg::SLACK_INF);
        status.freec_found    = freec_v_reg || apply_free;
        status.flip_done      = !flip_nxt_v ||
                                ((guard_reg + GUARD_W'(1)) > GUARD_W'(n_reg));
        status.sweep_last     = sweep_last;
    end

    // Memory port control.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_reg;
        wr_data = '0;
        if (cmd.op == mwas_pkg::OP_CLEAR)
            wr_en = 1'b1;
        else if ((cmd.op == mwas_pkg::OP_WRITE) &&
                 ({1'b0, row} < 7'(MAX_SIZE)) && ({1'b0, col} < 7'(MAX_SIZE)))
        begin
            wr_en   = 1'b1;
            wr_addr = cell_addr(row[IDX_W-1:0], col[IDX_W-1:0]);
            wr_data = weight;
        end
        rd_addr = (cmd.op == mwas_pkg::OP_INIT_RD) ? cell_addr(i_idx, j_idx) :
                                                     cell_addr(r_reg, j_idx);
    end

    always_comb
    begin
        clr_next     = clr_reg;
        n_next       = n_reg;
        unm_next     = unm_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        freec_next   = freec_reg;
        freec_v_next = freec_v_reg;
        guard_next   = guard_reg;
        mx_next      = mx_reg;
        tao_next     = tao_reg;
        total_next   = total_reg;
        rl_next      = rl_reg;
        cl_next      = cl_reg;
        slack_next   = slack_reg;
        parent_next  = parent_reg;
        rmate_next   = rmate_reg;
        cmate_next   = cmate_reg;
        row_m_next   = row_m_reg;
        col_m_next   = col_m_reg;
        tree_next    = tree_reg;
        pend_next    = pend_reg;
        res_v_next   = 1'b0;
        orow_next    = PW'(k_idx);
        ocol_next    = row_m_reg[k_idx] ? PW'(rmate_reg[k_idx]) : '0;
        last_next    = 1'b0;

        case (cmd.op)
            mwas_pkg::OP_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
            end
            mwas_pkg::OP_LOAD:
            begin
                n_next   = size_n;
                unm_next = size_n;
                i_next   = '0;
                j_next   = '0;
                mx_next  = '0;
            end
            mwas_pkg::OP_INIT_ACC:
            begin
                if (scan_last)
                begin
                    rl_next[i_idx]    = $signed({{(LW-WW){1'b0}}, mx_cur});
                    cl_next[i_idx]    = '0;
                    row_m_next[i_idx] = 1'b0;
                    col_m_next[i_idx] = 1'b0;
                    mx_next           = '0;
                    j_next            = '0;
                    i_next            = i_reg + CNT_W'(1);
                end
                else
                begin
                    mx_next = mx_cur;
                    j_next  = j_reg + CNT_W'(1);
                end
            end
            mwas_pkg::OP_PHASE_CHK:
            begin
                k_next     = '0;
                total_next = '0;
            end
            mwas_pkg::OP_PHASE_INIT:
            begin
                for (int q = 0; q < MAX_SIZE; q++)
                begin
                    tree_next[q]   = 1'b0;
                    parent_next[q] = '0;
                    slack_next[q]  = mwas_pkg::SLACK_INF;
                    pend_next[q]   = (CNT_W'(q) < n_reg) && !row_m_reg[q];
                end
            end
            mwas_pkg::OP_POP:
            begin
                if (pend_any)
                begin
                    pend_next[pop_idx] = 1'b0;
                    tree_next[pop_idx] = 1'b1;
                    r_next             = pop_idx;
                    j_next             = '0;
                end
                else
                begin
                    k_next   = '0;
                    tao_next = mwas_pkg::SLACK_INF;
                end
            end
            mwas_pkg::OP_SCAN_RD:
            begin
                if (scan_skip)
                    j_next = j_reg + CNT_W'(1);
            end
            mwas_pkg::OP_SCAN_EV:
            begin
                if (s_better)
                begin
                    slack_next[j_idx]  = s_val;
                    parent_next[j_idx] = r_reg;
                    if (s_val == '0)
                    begin
                        if (!col_m_reg[j_idx])
                        begin
                            c_next     = j_idx;
                            guard_next = '0;
                        end
                        else
                            pend_next[cmate_reg[j_idx]] = 1'b1;
                    end
                end
                j_next = j_reg + CNT_W'(1);
            end
            mwas_pkg::OP_TAO:
            begin
                tao_next     = tao_cand;
                freec_v_next = 1'b0;
                k_next       = sweep_last ? '0 : k_reg + CNT_W'(1);
            end
            mwas_pkg::OP_APPLY:
            begin
                if (tree_reg[k_idx])
                    rl_next[k_idx] = rl_reg[k_idx] - tao_reg;
                if (slack_reg[k_idx] == '0)
                    cl_next[k_idx] = cl_reg[k_idx] + tao_reg;
                else
                begin
                    slack_next[k_idx] = sl_sub;
                    if (sl_sub == '0)
                    begin
                        if (!col_m_reg[k_idx])
                        begin
                            freec_v_next = 1'b1;
                            freec_next   = k_idx;
                        end
                        else
                            pend_next[cmate_reg[k_idx]] = 1'b1;
                    end
                end
                k_next = sweep_last ? '0 : k_reg + CNT_W'(1);
                if (sweep_last)
                begin
                    c_next     = freec_next;
                    guard_next = '0;
                end
            end
            mwas_pkg::OP_FLIP:
            begin
                cmate_next[c_reg]    = flip_row;
                col_m_next[c_reg]    = 1'b1;
                rmate_next[flip_row] = c_reg;
                row_m_next[flip_row] = 1'b1;
                c_next               = flip_nxt;
                guard_next           = guard_reg + GUARD_W'(1);
                if (status.flip_done)
                    unm_next = unm_reg - CNT_W'(1);
            end
            mwas_pkg::OP_SUM:
            begin
                total_next = total_reg + rl_reg[k_idx] + cl_reg[k_idx];
                k_next     = sweep_last ? '0 : k_reg + CNT_W'(1);
            end
            mwas_pkg::OP_EMIT:
            begin
                res_v_next = 1'b1;
                last_next  = sweep_last;
                k_next     = sweep_last ? '0 : k_reg + CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= '0;
            n_reg       <= CNT_W'(1);
            unm_reg     <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            freec_v_reg <= 1'b0;
            guard_reg   <= '0;
            row_m_reg   <= '0;
            col_m_reg   <= '0;
            tree_reg    <= '0;
            pend_reg    <= '0;
            res_v_reg   <= 1'b0;
        end
        else
        begin
            clr_reg     <= clr_next;
            n_reg       <= n_next;
            unm_reg     <= unm_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            freec_v_reg <= freec_v_next;
            guard_reg   <= guard_next;
            row_m_reg   <= row_m_next;
            col_m_reg   <= col_m_next;
            tree_reg    <= tree_next;
            pend_reg    <= pend_next;
            res_v_reg   <= res_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        c_reg      <= c_next;
        freec_reg  <= freec_next;
        mx_reg     <= mx_next;
        tao_reg    <= tao_next;
        total_reg  <= total_next;
        rl_reg     <= rl_next;
        cl_reg     <= cl_next;
        slack_reg  <= slack_next;
        parent_reg <= parent_next;
        rmate_reg  <= rmate_next;
        cmate_reg  <= cmate_next;
        orow_reg   <= orow_next;
        ocol_reg   <= ocol_next;
        last_reg   <= last_next;
    end

    assign result_valid = res_v_reg;
    assign out_row      = orow_reg;
    assign out_col      = ocol_reg;
    assign total        = total_reg[mwas_pkg::TOTAL_W-1:0];
    assign last         = last_reg;

endmodule

// ----- sv/max_weight_assignment_solver.sv -----
// ----------------------------------------------------------------------------
// max_weight_assignment_solver
// Maximum-weight perfect assignment over a stored square weight matrix.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A write command
// (kind = 0) stores one 16-bit weight; writes to a row or column at or
// above MAX_SIZE are dropped. A solve command (kind = 1) runs the
// slack-based Hungarian method over the first n rows and columns, where n
// is the active_size register clamped to the range 1 to MAX_SIZE, and then
// delivers n results back to back, one per row in increasing order, each
// marked by result_valid for exactly one cycle. The receiver cannot stall
// these transfers, so it must take every result as it appears; total is
// the optimal weight and last flags the final row. A solve first loads
// the starting labels, then runs augmenting phases of column scans and
// relabel sweeps, then sums the labels and delivers the results; its pace
// is set by the single read port of the weight memory and the
// one-column-per-step sequencer. After reset the block clears the weight
// memory one entry per cycle with busy high; configuration writes are
// taken throughout. active_size is written through the APB port at
// address 0; the user must write it only while the block is idle, which
// the block itself does not enforce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module max_weight_assignment_solver #(
    parameter int MAX_SIZE = mwas_pkg::DEF_MAX_SIZE
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mwas_pkg::PADDR_W-1:0]        paddr,
    input  logic [mwas_pkg::PDATA_W-1:0]        pwdata,
    output logic [mwas_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic                                kind,
    input  logic [mwas_pkg::PORT_IDX_W-1:0]     row,
    input  logic [mwas_pkg::PORT_IDX_W-1:0]     col,
    input  logic [mwas_pkg::WEIGHT_W-1:0]       weight,
    output logic                                result_valid,
    output logic [mwas_pkg::PORT_IDX_W-1:0]     out_row,
    output logic [mwas_pkg::PORT_IDX_W-1:0]     out_col,
    output logic [mwas_pkg::TOTAL_W-1:0]        total,
    output logic                                last
);

    logic [mwas_pkg::SIZE_W-1:0] active_size_reg, active_size_next;
    mwas_pkg::dp_cmd_t           cmd;
    mwas_pkg::dp_status_t        status;

    // The only register sits at byte address 0; address bit 2 selects
    // anything beyond it, which reads as zero and ignores writes.
    always_comb
    begin
        active_size_next = active_size_reg;
        if (psel && penable && pwrite && pready && !paddr[2])
            active_size_next = pwdata[mwas_pkg::SIZE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_size_reg <= mwas_pkg::DEF_ACTIVE_SIZE;
        else
            active_size_reg <= active_size_next;
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 :
                    {{(mwas_pkg::PDATA_W - mwas_pkg::SIZE_W){1'b0}}, active_size_reg};

    mwas_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    mwas_datapath #(
        .MAX_SIZE (MAX_SIZE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .active_size  (active_size_reg),
        .row          (row),
        .col          (col),
        .weight       (weight),
        .status       (status),
        .result_valid (result_valid),
        .out_row      (out_row),
        .out_col      (out_col),
        .total        (total),
        .last         (last)
    );

endmodule

// ----- sv/mwas_checker.sv -----
// ----------------------------------------------------------------------------
// mwas_checker
// Port-level checks of the result sequence, bound to the solver top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mwas_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                busy,
    input logic                                result_valid,
    input logic [mwas_pkg::PORT_IDX_W-1:0]     out_row,
    input logic                                last
);

    // The final-row flag only rides on a result transfer.
    `ASSERT_NOW(a_last_on_valid, last, result_valid)

    // While results remain to be delivered the block stays busy.
    `ASSERT_NOW(a_busy_mid_burst, result_valid && !last, busy)

    // Results arrive back to back with the row index counting up.
    `ASSERT_NEXT(a_rows_seq, result_valid && !last, result_valid && out_row == $past(out_row) + 6'd1)

endmodule

bind max_weight_assignment_solver mwas_checker u_mwas_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .out_row      (out_row),
    .last         (last)
);
